// File: design/stpg_pkg.sv
// ----------------------------------------------------------------------------
// stpg_pkg
// Shared constants and types for the shape texture pixel generator.
// ----------------------------------------------------------------------------
package stpg_pkg;

    localparam int COORD_BITS_DEF = 10;

    localparam logic [1:0] MODE_CIRCLE  = 2'd0;
    localparam logic [1:0] MODE_DCIRCLE = 2'd1;
    localparam logic [1:0] MODE_TRI     = 2'd2;
    localparam logic [1:0] MODE_DTRI    = 2'd3;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_TEX_W   = 3'd1;
    localparam logic [2:0] REG_INNER_W = 3'd2;
    localparam logic [2:0] REG_OUTER   = 3'd3;
    localparam logic [2:0] REG_INNER   = 3'd4;

    localparam int TEX_W_RST   = 64;
    localparam int INNER_W_RST = 32;

    typedef struct packed {
        logic valid;
        logic in_w;
        logic in_n;
        logic tri_o;
        logic tri_i;
    } t_flags;

endpackage

// File: design/stpg_sqrt_cell.sv
// ----------------------------------------------------------------------------
// stpg_sqrt_cell
// One digit step of the integer square root chain.
// ----------------------------------------------------------------------------
module stpg_sqrt_cell #(
    parameter int VW = 38,
    parameter int RW = 21,
    parameter int IW = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stpg_pkg::t_flags     i_flags,
    input  logic [IW-1:0]        i_idx,
    input  logic [VW-1:0]        i_v,
    input  logic [RW-1:0]        i_r,
    input  logic [RW-3:0]        i_q,
    output stpg_pkg::t_flags     o_flags,
    output logic [IW-1:0]        o_idx,
    output logic [VW-1:0]        o_v,
    output logic [RW-1:0]        o_r,
    output logic [RW-3:0]        o_q
);
    import stpg_pkg::*;

    t_flags          r_flags;
    logic [IW-1:0]   r_idx;
    logic [VW-1:0]   r_v;
    logic [RW-1:0]   r_r;
    logic [RW-3:0]   r_q;
    logic [RW-1:0]   sh;
    logic [RW-1:0]   trial;
    logic            ge;

    assign sh    = {i_r[RW-3:0], i_v[VW-1:VW-2]};
    assign trial = {i_q, 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.valid <= 1'b0;
        end else begin
            r_flags.valid <= i_flags.valid;
        end
        r_flags.in_w  <= i_flags.in_w;
        r_flags.in_n  <= i_flags.in_n;
        r_flags.tri_o <= i_flags.tri_o;
        r_flags.tri_i <= i_flags.tri_i;
        r_idx <= i_idx;
        r_v   <= {i_v[VW-3:0], 2'b00};
        r_r   <= ge ? (sh - trial) : sh;
        r_q   <= {i_q[RW-4:0], ge};
    end

    assign o_flags = r_flags;
    assign o_idx   = r_idx;
    assign o_v     = r_v;
    assign o_r     = r_r;
    assign o_q     = r_q;
endmodule

// File: design/stpg_div_cell.sv
// ----------------------------------------------------------------------------
// stpg_div_cell
// One quotient bit step of the restoring divider chain.
// ----------------------------------------------------------------------------
module stpg_div_cell #(
    parameter int DW = 27,
    parameter int NW = 11,
    parameter int IW = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [NW-1:0]        i_n,
    input  stpg_pkg::t_flags     i_flags,
    input  logic [IW-1:0]        i_idx,
    input  logic [DW-1:0]        i_d,
    input  logic [NW:0]          i_rem,
    input  logic [DW-1:0]        i_q,
    output stpg_pkg::t_flags     o_flags,
    output logic [IW-1:0]        o_idx,
    output logic [DW-1:0]        o_d,
    output logic [NW:0]          o_rem,
    output logic [DW-1:0]        o_q
);
    import stpg_pkg::*;

    t_flags          r_flags;
    logic [IW-1:0]   r_idx;
    logic [DW-1:0]   r_d;
    logic [NW:0]     r_rem;
    logic [DW-1:0]   r_q;
    logic [NW:0]     sh;
    logic            ge;

    assign sh = {i_rem[NW-1:0], i_d[DW-1]};
    assign ge = (sh >= {1'b0, i_n});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.valid <= 1'b0;
        end else begin
            r_flags.valid <= i_flags.valid;
        end
        r_flags.in_w  <= i_flags.in_w;
        r_flags.in_n  <= i_flags.in_n;
        r_flags.tri_o <= i_flags.tri_o;
        r_flags.tri_i <= i_flags.tri_i;
        r_idx <= i_idx;
        r_d   <= {i_d[DW-2:0], 1'b0};
        r_rem <= ge ? (sh - {1'b0, i_n}) : sh;
        r_q   <= {i_q[DW-2:0], ge};
    end

    assign o_flags = r_flags;
    assign o_idx   = r_idx;
    assign o_d     = r_d;
    assign o_rem   = r_rem;
    assign o_q     = r_q;
endmodule

// File: design/shape_texture_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// shape_texture_pixel_generator_unit
// Circle / triangle texture pixel generator with shaded inner disc.
// ----------------------------------------------------------------------------
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-----------------------------
//  pixel in | start && !busy                 | i_pos_x, i_pos_y
//  result   | o_valid (one cycle strobe)     | o_pixel_word, o_write_enable,
//           |                                | o_pixel_index
//  config   | psel && penable && pwrite      | paddr, pwdata / prdata
//
//  One beat per cycle; busy is always low. The pipeline holds two front
//  stages, COORD_BITS+9 square root cells, COORD_BITS+17 divider cells,
//  a multiply stage and the output register.
//  Reset is synchronous; it empties the pipeline and loads register defaults.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module shape_texture_pixel_generator_unit #(
    parameter int COORD_BITS = stpg_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [COORD_BITS-1:0]   i_pos_x,
    input  logic [COORD_BITS-1:0]   i_pos_y,
    output logic                    o_valid,
    output logic [31:0]             o_pixel_word,
    output logic                    o_write_enable,
    output logic [2*COORD_BITS-1:0] o_pixel_index,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import stpg_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int WB   = C + 1;
    localparam int IW   = 2 * C;
    localparam int SQW  = 2 * C + 2;
    localparam int SW   = 2 * C + 3;
    localparam int TW   = C + 4;
    localparam int SQ_N = C + 9;
    localparam int VW   = 2 * SQ_N;
    localparam int RW   = SQ_N + 2;
    localparam int DW   = SQ_N + 8;
    localparam int LAT  = 4 + SQ_N + DW;

    // configuration
    logic [1:0]    r_mode;
    logic [WB-1:0] r_tex_w;
    logic [WB-1:0] r_inner_w;
    logic [31:0]   r_outer;
    logic [31:0]   r_inner;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_CIRCLE;
            r_tex_w   <= WB'(TEX_W_RST);
            r_inner_w <= WB'(INNER_W_RST);
            r_outer   <= 32'd0;
            r_inner   <= 32'd0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_MODE:    r_mode    <= pwdata[1:0];
                REG_TEX_W:   r_tex_w   <= pwdata[WB-1:0];
                REG_INNER_W: r_inner_w <= pwdata[WB-1:0];
                REG_OUTER:   r_outer   <= pwdata;
                REG_INNER:   r_inner   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_MODE:    prdata = {30'd0, r_mode};
            REG_TEX_W:   prdata = {{(32-WB){1'b0}}, r_tex_w};
            REG_INNER_W: prdata = {{(32-WB){1'b0}}, r_inner_w};
            REG_OUTER:   prdata = r_outer;
            REG_INNER:   prdata = r_inner;
            default:     prdata = 32'd0;
        endcase
    end

    // stage 1: squares, index, triangle edge tests
    logic signed [TW-1:0]  sx, sy, sw, sn;
    logic signed [TW-1:0]  ao, bo, ai, bi, kk;
    logic signed [C+1:0]   dx, dy;
    logic signed [2*C+3:0] dx2, dy2;
    logic [2*WB-1:0]       w2, n2;
    logic [IW:0]           yw;
    logic                  tri_o, tri_i;

    assign sx  = $signed({{(TW-C){1'b0}}, i_pos_x});
    assign sy  = $signed({{(TW-C){1'b0}}, i_pos_y});
    assign sw  = $signed({{(TW-WB){1'b0}}, r_tex_w});
    assign sn  = $signed({{(TW-WB){1'b0}}, r_inner_w});
    assign ao  = TW'(sy - sw + 2 * sx);
    assign bo  = TW'(2 * sx - sy - sw);
    assign kk  = TW'(2 * sn - sw);
    assign ai  = TW'(sy + 2 * sx - 2 * sw + sn);
    assign bi  = TW'(2 * sx - sy - sn);
    assign dx  = $signed({1'b0, i_pos_x, 1'b0}) - $signed({1'b0, r_tex_w});
    assign dy  = $signed({1'b0, i_pos_y, 1'b0}) - $signed({1'b0, r_tex_w});
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;
    assign w2  = r_tex_w * r_tex_w;
    assign n2  = r_inner_w * r_inner_w;
    assign yw  = i_pos_y * r_tex_w;
    assign tri_o = (r_tex_w != '0) && (ao > 0) && (bo < 0);

    always_comb begin
        priority if (kk > 0) begin
            tri_i = (ai > 0) && (bi < 0);
        end else if (kk < 0) begin
            tri_i = (ai < 0) && (bi > 0);
        end else begin
            tri_i = 1'b0;
        end
    end

    t_flags          r_f1;
    logic [SQW-1:0]  r_dx2, r_dy2, r_w2, r_n2;
    logic [IW-1:0]   r_idx1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1.valid <= 1'b0;
        end else begin
            r_f1.valid <= start;
        end
        r_f1.in_w  <= 1'b0;
        r_f1.in_n  <= 1'b0;
        r_f1.tri_o <= tri_o;
        r_f1.tri_i <= tri_i;
        r_dx2  <= dx2[SQW-1:0];
        r_dy2  <= dy2[SQW-1:0];
        r_w2   <= w2;
        r_n2   <= n2;
        r_idx1 <= IW'(yw) + {{(IW-C){1'b0}}, i_pos_x};
    end

    // stage 2: distance sum and circle tests
    logic [SW-1:0] sum;
    t_flags        r_f2;
    logic [IW-1:0] r_idx2;
    logic [VW-1:0] r_v2;

    assign sum = {1'b0, r_dx2} + {1'b0, r_dy2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2.valid <= 1'b0;
        end else begin
            r_f2.valid <= r_f1.valid;
        end
        r_f2.in_w  <= (sum < {1'b0, r_w2});
        r_f2.in_n  <= (sum < {1'b0, r_n2});
        r_f2.tri_o <= r_f1.tri_o;
        r_f2.tri_i <= r_f1.tri_i;
        r_idx2 <= r_idx1;
        r_v2   <= {1'b0, sum, 14'd0};
    end

    // square root chain
    t_flags        sq_f   [0:SQ_N];
    logic [IW-1:0] sq_idx [0:SQ_N];
    logic [VW-1:0] sq_v   [0:SQ_N];
    logic [RW-1:0] sq_r   [0:SQ_N];
    logic [RW-3:0] sq_q   [0:SQ_N];

    assign sq_f[0]   = r_f2;
    assign sq_idx[0] = r_idx2;
    assign sq_v[0]   = r_v2;
    assign sq_r[0]   = '0;
    assign sq_q[0]   = '0;

    for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
        stpg_sqrt_cell #(.VW(VW), .RW(RW), .IW(IW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_flags (sq_f[g]),
            .i_idx   (sq_idx[g]),
            .i_v     (sq_v[g]),
            .i_r     (sq_r[g]),
            .i_q     (sq_q[g]),
            .o_flags (sq_f[g+1]),
            .o_idx   (sq_idx[g+1]),
            .o_v     (sq_v[g+1]),
            .o_r     (sq_r[g+1]),
            .o_q     (sq_q[g+1])
        );
    end

    // divider chain
    t_flags        dv_f   [0:DW];
    logic [IW-1:0] dv_idx [0:DW];
    logic [DW-1:0] dv_d   [0:DW];
    logic [WB:0]   dv_rem [0:DW];
    logic [DW-1:0] dv_q   [0:DW];

    assign dv_f[0]   = sq_f[SQ_N];
    assign dv_idx[0] = sq_idx[SQ_N];
    assign dv_d[0]   = {sq_q[SQ_N], 8'd0};
    assign dv_rem[0] = '0;
    assign dv_q[0]   = '0;

    for (genvar g = 0; g < DW; g++) begin : g_div
        stpg_div_cell #(.DW(DW), .NW(WB), .IW(IW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_n     (r_inner_w),
            .i_flags (dv_f[g]),
            .i_idx   (dv_idx[g]),
            .i_d     (dv_d[g]),
            .i_rem   (dv_rem[g]),
            .i_q     (dv_q[g]),
            .o_flags (dv_f[g+1]),
            .o_idx   (dv_idx[g+1]),
            .o_d     (dv_d[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_q     (dv_q[g+1])
        );
    end

    // scale and channel multiply
    logic [16:0]   scale;
    logic [DW-1:0] qf;
    logic [24:0]   p0, p1, p2;
    t_flags        r_fm;
    logic [IW-1:0] r_idxm;
    logic [23:0]   r_shade;

    assign qf    = dv_q[DW];
    assign scale = (|qf[DW-1:16]) ? 17'd0 : (17'h10000 - {1'b0, qf[15:0]});
    assign p0    = r_inner[7:0]   * scale;
    assign p1    = r_inner[15:8]  * scale;
    assign p2    = r_inner[23:16] * scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fm.valid <= 1'b0;
        end else begin
            r_fm.valid <= dv_f[DW].valid;
        end
        r_fm.in_w  <= dv_f[DW].in_w;
        r_fm.in_n  <= dv_f[DW].in_n;
        r_fm.tri_o <= dv_f[DW].tri_o;
        r_fm.tri_i <= dv_f[DW].tri_i;
        r_idxm  <= dv_idx[DW];
        r_shade <= {p2[23:16], p1[23:16], p0[23:16]};
    end

    // output select
    logic [31:0]   word;
    logic          we;
    logic          r_valid;
    logic [31:0]   r_word;
    logic          r_we;
    logic [IW-1:0] r_idx;

    always_comb begin
        we = 1'b1;
        unique case (r_mode)
            MODE_CIRCLE:  word = r_fm.in_w ? r_outer : 32'd0;
            MODE_DCIRCLE: word = r_fm.in_n ? {8'd0, r_shade} :
                                 (r_fm.in_w ? r_outer : 32'd0);
            MODE_TRI:     word = r_fm.tri_o ? r_outer : 32'd0;
            default: begin
                priority if (r_fm.tri_i) begin
                    word = r_inner;
                end else if (r_fm.tri_o) begin
                    word = r_outer;
                end else begin
                    word = 32'd0;
                    we   = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_fm.valid;
        end
        r_word <= word;
        r_we   <= we;
        r_idx  <= r_idxm;
    end

    assign o_valid        = r_valid;
    assign o_pixel_word   = r_word;
    assign o_write_enable = r_we;
    assign o_pixel_index  = r_idx;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("pixel beat lost in pipeline");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without pixel beat");

    a_we_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |-> (r_mode == MODE_DTRI))
        else $error("write suppressed outside dual triangle mode");

endmodule

// File: bench/shape_texture_pixel_generator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_texture_pixel_generator_unit_test
// Drives pixel coordinates through the generator under all four shape modes
// and several register settings, predicts each result from the geometry and
// checks every strobed result against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module shape_texture_pixel_generator_unit_test;
    import stpg_pkg::*;

    localparam int CB      = 10;
    localparam int LATENCY = 2 * CB + 30;

    typedef struct {
        logic [31:0]     word;
        logic            we;
        logic [2*CB-1:0] index;
    } t_pixel;

    class pixel_scoreboard;
        t_pixel pending[$];
        int     errors;
        logic [1:0]  mode;
        logic [10:0] tex_w;
        logic [10:0] inn_w;
        logic [31:0] outer_col;
        logic [31:0] inner_col;

        function new();
            errors = 0;
            mode = MODE_CIRCLE;
            tex_w = TEX_W_RST;
            inn_w = INNER_W_RST;
            outer_col = 0;
            inner_col = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function bit outer_tri(longint w, longint x, longint y);
            return (w * (y - w) + 2 * w * x > 0) && (w * (w - y) - 2 * w * (w - x) < 0);
        endfunction

        function bit inner_tri(longint w, longint n, longint x, longint y);
            longint k;
            k = 2 * n - w;
            return (k * (y - n) - 2 * (w - 2 * n) * (x - w + n) > 0) &&
                   (k * (n - y) - 2 * k * (n - x) < 0);
        endfunction

        function logic [31:0] shaded(longint unsigned s, longint unsigned n);
            longint unsigned dq, q, sc, ch;
            logic [31:0] o;
            dq = int_sqrt(s * 16384);
            q = (n != 0) ? (dq << 8) / n : 0;
            sc = (q >= 65536) ? 0 : 65536 - q;
            o = 0;
            for (int c = 0; c < 3; c++) begin
                ch = (inner_col >> (8 * c)) & 8'hff;
                o[8*c +: 8] = (ch * sc) >> 16;
            end
            return o;
        endfunction

        function void note_pixel(logic [CB-1:0] px, logic [CB-1:0] py);
            longint x, y, w, n, dx, dy;
            longint unsigned s;
            t_pixel p;
            x = px; y = py; w = tex_w; n = inn_w;
            dx = 2 * x - w; dy = 2 * y - w;
            s = dx * dx + dy * dy;
            p.word = 0;
            p.we = 1;
            case (mode)
                MODE_CIRCLE: p.word = (s < w * w) ? outer_col : 0;
                MODE_DCIRCLE: begin
                    if (s < n * n) p.word = shaded(s, n);
                    else p.word = (s < w * w) ? outer_col : 0;
                end
                MODE_TRI: p.word = outer_tri(w, x, y) ? outer_col : 0;
                default: begin
                    if (inner_tri(w, n, x, y)) p.word = inner_col;
                    else if (outer_tri(w, x, y)) p.word = outer_col;
                    else p.we = 0;
                end
            endcase
            p.index = x + y * w;
            pending.push_back(p);
        endfunction

        function void check_pixel(logic [31:0] word, logic we, logic [2*CB-1:0] index);
            t_pixel p;
            if (pending.size() == 0) begin
                $error("unexpected result beat");
                errors++;
                return;
            end
            p = pending.pop_front();
            if (word !== p.word) begin
                $error("pixel_word expected %h actual %h", p.word, word);
                errors++;
            end
            if (we !== p.we) begin
                $error("write_enable expected %b actual %b", p.we, we);
                errors++;
            end
            if (index !== p.index) begin
                $error("pixel_index expected %h actual %h", p.index, index);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy;
    logic [CB-1:0] i_pos_x, i_pos_y;
    logic o_valid, o_write_enable;
    logic [31:0] o_pixel_word;
    logic [2*CB-1:0] o_pixel_index;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;

    pixel_scoreboard sb;

    shape_texture_pixel_generator_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .o_valid(o_valid),
        .o_pixel_word(o_pixel_word), .o_write_enable(o_write_enable),
        .o_pixel_index(o_pixel_index), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_pixel(o_pixel_word, o_write_enable, o_pixel_index);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_MODE:    sb.mode = val[1:0];
            REG_TEX_W:   sb.tex_w = val[10:0];
            REG_INNER_W: sb.inn_w = val[10:0];
            REG_OUTER:   sb.outer_col = val;
            default:     sb.inner_col = val;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic send_pixel(logic [CB-1:0] x, logic [CB-1:0] y);
        start <= 1; i_pos_x <= x; i_pos_y <= y;
        do @(posedge i_clk); while (busy);
        sb.note_pixel(x, y);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        start <= 0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    task automatic setup(logic [1:0] m, logic [10:0] w, logic [10:0] n);
        write_reg(REG_MODE, m);
        write_reg(REG_TEX_W, w);
        write_reg(REG_INNER_W, n);
        write_reg(REG_OUTER, $urandom);
        write_reg(REG_INNER, $urandom);
    endtask

    task automatic random_burst(int count, logic [10:0] w);
        int left, len;
        logic [CB-1:0] x, y;
        left = count;
        while (left > 0) begin
            len = $urandom_range(1, 40);
            for (int k = 0; k < len && left > 0; k++) begin
                if ($urandom_range(0, 9) == 0 || w == 0) begin
                    x = $urandom; y = $urandom;
                end else begin
                    x = $urandom_range(0, (w > 1024 ? 1024 : w) - 1);
                    y = $urandom_range(0, (w > 1024 ? 1024 : w) - 1);
                end
                send_pixel(x, y);
                left--;
            end
            if ($urandom_range(0, 2) != 0) idle_gap();
        end
        start <= 0;
    endtask

    initial begin
        logic [10:0] w, n;
        sb = new();
        i_rst_n = 0; start = 0; i_pos_x = 0; i_pos_y = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // reset defaults, then directed corners in each mode
        send_pixel(32, 32);
        send_pixel(0, 0);
        start <= 0;
        drain();
        for (int m = 0; m < 4; m++) begin
            setup(m[1:0], 64, 32);
            send_pixel(32, 32);
            send_pixel(0, 0);
            send_pixel(63, 63);
            send_pixel(32, 1);
            send_pixel(10'h3ff, 10'h3ff);
            start <= 0;
            drain();
        end
        setup(MODE_DCIRCLE, 2047, 0);
        send_pixel(10'h3ff, 0);
        send_pixel(10'h200, 10'h3ff);
        start <= 0;
        drain();
        setup(MODE_DTRI, 0, 2047);
        send_pixel(0, 0);
        send_pixel(10'h155, 10'h2aa);
        start <= 0;
        drain();
        setup(MODE_CIRCLE, 1024, 1024);
        send_pixel(512, 512);
        send_pixel(1023, 0);
        start <= 0;
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: w = $urandom_range(1, 32);
                1: w = $urandom_range(1, 1024);
                2: w = (ph < 8) ? 1 : 1024;
                default: w = $urandom_range(0, 2047);
            endcase
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, w);
            setup(ph[1:0], w, n);
            random_burst(100, w);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
